// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check sampled on the rising edge, off while reset is asserted
`define SCP_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scp assertion failed");

// concurrent check that also holds during reset
`define SCP_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("scp assertion failed");

`endif

// ----- design/scp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package scp_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int T_FRAC_BITS_DEF = 24;

    // outcome of clamping the projection parameter
    typedef enum logic [1:0] {
        REGION_START    = 2'd0,
        REGION_INTERIOR = 2'd1,
        REGION_END      = 2'd2
    } region_t;

    // cycles from accepted start to done strobe
    function automatic int scp_latency(input int coord_width, input int t_frac_bits);
        return t_frac_bits + coord_width + 12;
    endfunction

endpackage

`default_nettype wire

// ----- design/segment_closest_point_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// closest point on a 2-D segment to a query point, with distance. one transfer
// per cycle: busy is held low, start may be high every cycle, and each accepted
// transfer yields one result strobed on done, in order. the receiver cannot
// stall; results must be captured in the cycle done is high. the pipeline runs
// through the front end, the restoring divider (one bit of t per stage), the
// interpolation and the square root (one root bit per stage, COORD_WIDTH + 2
// stages). no state is kept between items.
module segment_closest_point_core #(
    parameter int COORD_WIDTH = scp_pkg::COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = scp_pkg::T_FRAC_BITS_DEF
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             start,
    output logic                            busy,
    input  wire  signed [COORD_WIDTH-1:0]   start_x,
    input  wire  signed [COORD_WIDTH-1:0]   start_y,
    input  wire  signed [COORD_WIDTH-1:0]   end_x,
    input  wire  signed [COORD_WIDTH-1:0]   end_y,
    input  wire  signed [COORD_WIDTH-1:0]   query_x,
    input  wire  signed [COORD_WIDTH-1:0]   query_y,
    output logic                            done,
    output logic signed [COORD_WIDTH-1:0]   closest_x,
    output logic signed [COORD_WIDTH-1:0]   closest_y,
    output logic [COORD_WIDTH:0]            distance,
    output logic [1:0]                      region,
    output logic                            degenerate
);
    import scp_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int SW = 2 * DW + 1;
    // divider sideband: region, degenerate, start, delta, query
    localparam int SB = 2 + 1 + 4 * W + 2 * DW;

    // pipeline always advances, so a new transfer is taken every cycle
    assign busy = 1'b0;

    // front end: differences, products, sums, clamp decision
    logic                 f_valid;
    region_t              f_region;
    logic                 f_degen;
    logic [SW-1:0]        f_dot, f_len2;
    logic signed [W-1:0]  f_sx, f_sy, f_qx, f_qy;
    logic signed [DW-1:0] f_dx, f_dy;

    scp_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start && !busy),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .query_x    (query_x),
        .query_y    (query_y),
        .out_valid  (f_valid),
        .out_region (f_region),
        .out_degen  (f_degen),
        .out_dot    (f_dot),
        .out_len2   (f_len2),
        .out_sx     (f_sx),
        .out_sy     (f_sy),
        .out_dx     (f_dx),
        .out_dy     (f_dy),
        .out_qx     (f_qx),
        .out_qy     (f_qy)
    );

    // t = dot / len2; only meaningful for interior items, where 0 < dot < len2
    logic [SW-1:0]          div_num;
    logic                   d_valid;
    logic [T_FRAC_BITS-1:0] d_t;
    logic [SB-1:0]          d_side;
    region_t                d_region;
    logic                   d_degen;
    logic signed [W-1:0]    d_sx, d_sy, d_qx, d_qy;
    logic signed [DW-1:0]   d_dx, d_dy;

    // keep the partial remainder below the divisor for clamped items too
    assign div_num = (f_region == REGION_INTERIOR) ? f_dot : '0;

    scp_divider #(
        .NUM_WIDTH  (SW),
        .QUOT_BITS  (T_FRAC_BITS),
        .SIDE_WIDTH (SB)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_num    (div_num),
        .in_den    (f_len2),
        .in_side   ({f_region, f_degen, f_sx, f_sy, f_dx, f_dy, f_qx, f_qy}),
        .out_valid (d_valid),
        .out_quot  (d_t),
        .out_side  (d_side)
    );

    assign d_region = region_t'(d_side[SB-1 -: 2]);
    assign {d_degen, d_sx, d_sy, d_dx, d_dy, d_qx, d_qy} = d_side[SB-3:0];

    // closest point
    logic                i_valid;
    region_t             i_region;
    logic                i_degen;
    logic signed [W-1:0] i_cx, i_cy, i_qx, i_qy;

    scp_interp #(
        .COORD_WIDTH (COORD_WIDTH),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_interp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (d_valid),
        .in_t       (d_t),
        .in_region  (d_region),
        .in_degen   (d_degen),
        .in_sx      (d_sx),
        .in_sy      (d_sy),
        .in_dx      (d_dx),
        .in_dy      (d_dy),
        .in_qx      (d_qx),
        .in_qy      (d_qy),
        .out_valid  (i_valid),
        .out_region (i_region),
        .out_degen  (i_degen),
        .out_cx     (i_cx),
        .out_cy     (i_cy),
        .out_qx     (i_qx),
        .out_qy     (i_qy)
    );

    // distance: squares, sum, rounded square root, saturation
    region_t o_region;

    scp_dist #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (i_valid),
        .in_region  (i_region),
        .in_degen   (i_degen),
        .in_cx      (i_cx),
        .in_cy      (i_cy),
        .in_qx      (i_qx),
        .in_qy      (i_qy),
        .out_valid  (done),
        .out_region (o_region),
        .out_degen  (degenerate),
        .out_cx     (closest_x),
        .out_cy     (closest_y),
        .out_dist   (distance)
    );

    assign region = o_region;

endmodule

`default_nettype wire

// ----- design/scp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module scp_front #(
    parameter int COORD_WIDTH = 32
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    input  wire  signed [COORD_WIDTH-1:0]    start_x,
    input  wire  signed [COORD_WIDTH-1:0]    start_y,
    input  wire  signed [COORD_WIDTH-1:0]    end_x,
    input  wire  signed [COORD_WIDTH-1:0]    end_y,
    input  wire  signed [COORD_WIDTH-1:0]    query_x,
    input  wire  signed [COORD_WIDTH-1:0]    query_y,
    output logic                             out_valid,
    output scp_pkg::region_t                 out_region,
    output logic                             out_degen,
    output logic [2*COORD_WIDTH+2:0]         out_dot,
    output logic [2*COORD_WIDTH+2:0]         out_len2,
    output logic signed [COORD_WIDTH-1:0]    out_sx,
    output logic signed [COORD_WIDTH-1:0]    out_sy,
    output logic signed [COORD_WIDTH:0]      out_dx,
    output logic signed [COORD_WIDTH:0]      out_dy,
    output logic signed [COORD_WIDTH-1:0]    out_qx,
    output logic signed [COORD_WIDTH-1:0]    out_qy
);
    import scp_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    // stage 1: differences
    logic                 v1_reg;
    logic                 degen1_reg;
    logic signed [W-1:0]  sx1_reg, sy1_reg, qx1_reg, qy1_reg;
    logic signed [DW-1:0] dx1_reg, dy1_reg, wx1_reg, wy1_reg;
    // stage 2: products
    logic                 v2_reg;
    logic                 degen2_reg;
    logic signed [W-1:0]  sx2_reg, sy2_reg, qx2_reg, qy2_reg;
    logic signed [DW-1:0] dx2_reg, dy2_reg;
    logic signed [PW-1:0] pxx2_reg, pyy2_reg, pdx2_reg, pdy2_reg;
    // stage 3: sums
    logic                 v3_reg;
    logic                 degen3_reg;
    logic signed [W-1:0]  sx3_reg, sy3_reg, qx3_reg, qy3_reg;
    logic signed [DW-1:0] dx3_reg, dy3_reg;
    logic signed [SW-1:0] dot3_reg;
    logic [SW-1:0]        len3_reg;
    // stage 4: classification
    logic                 v4_reg;
    region_t              region4_reg, region4_next;

    logic signed [SW-1:0] pxx_ext, pyy_ext, pdx_ext, pdy_ext, len_sum;

    assign pxx_ext = SW'(pxx2_reg);
    assign pyy_ext = SW'(pyy2_reg);
    assign pdx_ext = SW'(pdx2_reg);
    assign pdy_ext = SW'(pdy2_reg);
    assign len_sum = pxx_ext + pyy_ext;

    always_comb
    begin
        priority if (dot3_reg[SW-1] || (dot3_reg == '0))
        begin
            region4_next = REGION_START;
        end
        else if (dot3_reg >= $signed(len3_reg))
        begin
            region4_next = REGION_END;
        end
        else
        begin
            region4_next = REGION_INTERIOR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        degen1_reg <= (start_x == end_x) && (start_y == end_y);
        sx1_reg    <= start_x;
        sy1_reg    <= start_y;
        qx1_reg    <= query_x;
        qy1_reg    <= query_y;
        dx1_reg    <= DW'(end_x) - DW'(start_x);
        dy1_reg    <= DW'(end_y) - DW'(start_y);
        wx1_reg    <= DW'(query_x) - DW'(start_x);
        wy1_reg    <= DW'(query_y) - DW'(start_y);

        degen2_reg <= degen1_reg;
        sx2_reg    <= sx1_reg;
        sy2_reg    <= sy1_reg;
        qx2_reg    <= qx1_reg;
        qy2_reg    <= qy1_reg;
        dx2_reg    <= dx1_reg;
        dy2_reg    <= dy1_reg;
        pxx2_reg   <= dx1_reg * dx1_reg;
        pyy2_reg   <= dy1_reg * dy1_reg;
        pdx2_reg   <= wx1_reg * dx1_reg;
        pdy2_reg   <= wy1_reg * dy1_reg;

        degen3_reg <= degen2_reg;
        sx3_reg    <= sx2_reg;
        sy3_reg    <= sy2_reg;
        qx3_reg    <= qx2_reg;
        qy3_reg    <= qy2_reg;
        dx3_reg    <= dx2_reg;
        dy3_reg    <= dy2_reg;
        len3_reg   <= len_sum;
        dot3_reg   <= pdx_ext + pdy_ext;

        region4_reg <= region4_next;
        out_degen   <= degen3_reg;
        out_dot     <= dot3_reg;
        out_len2    <= len3_reg;
        out_sx      <= sx3_reg;
        out_sy      <= sy3_reg;
        out_dx      <= dx3_reg;
        out_dy      <= dy3_reg;
        out_qx      <= qx3_reg;
        out_qy      <= qy3_reg;
    end

    assign out_valid  = v4_reg;
    assign out_region = region4_reg;

endmodule

`default_nettype wire

// ----- design/scp_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per stage
module scp_divider #(
    parameter int NUM_WIDTH  = 67,
    parameter int QUOT_BITS  = 24,
    parameter int SIDE_WIDTH = 8
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    input  wire  [NUM_WIDTH-1:0]    in_num,
    input  wire  [NUM_WIDTH-1:0]    in_den,
    input  wire  [SIDE_WIDTH-1:0]   in_side,
    output logic                    out_valid,
    output logic [QUOT_BITS-1:0]    out_quot,
    output logic [SIDE_WIDTH-1:0]   out_side
);
    logic                  v_reg    [QUOT_BITS];
    logic [NUM_WIDTH-1:0]  rem_reg  [QUOT_BITS];
    logic [NUM_WIDTH-1:0]  den_reg  [QUOT_BITS];
    logic [QUOT_BITS-1:0]  quot_reg [QUOT_BITS];
    logic [SIDE_WIDTH-1:0] side_reg [QUOT_BITS];

    for (genvar i = 0; i < QUOT_BITS; i++)
    begin : g_stage
        logic                  v_in;
        logic [NUM_WIDTH-1:0]  rem_in, den_in;
        logic [QUOT_BITS-1:0]  quot_in;
        logic [SIDE_WIDTH-1:0] side_in;
        logic [NUM_WIDTH:0]    shifted, diff;
        logic                  ge;

        if (i == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = in_num;
            assign den_in  = in_den;
            assign quot_in = '0;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign v_in    = v_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign den_in  = den_reg[i-1];
            assign quot_in = quot_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        assign shifted = {rem_in, 1'b0};
        assign diff    = shifted - {1'b0, den_in};
        assign ge      = (shifted >= {1'b0, den_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else
            begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i]  <= ge ? diff[NUM_WIDTH-1:0] : shifted[NUM_WIDTH-1:0];
            den_reg[i]  <= den_in;
            quot_reg[i] <= {quot_in[QUOT_BITS-2:0], ge};
            side_reg[i] <= side_in;
        end
    end

    assign out_valid = v_reg[QUOT_BITS-1];
    assign out_quot  = quot_reg[QUOT_BITS-1];
    assign out_side  = side_reg[QUOT_BITS-1];

endmodule

`default_nettype wire

// ----- design/scp_interp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module scp_interp #(
    parameter int COORD_WIDTH = 32,
    parameter int T_FRAC_BITS = 24
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             in_valid,
    input  wire  [T_FRAC_BITS-1:0]          in_t,
    input  scp_pkg::region_t                in_region,
    input  wire                             in_degen,
    input  wire  signed [COORD_WIDTH-1:0]   in_sx,
    input  wire  signed [COORD_WIDTH-1:0]   in_sy,
    input  wire  signed [COORD_WIDTH:0]     in_dx,
    input  wire  signed [COORD_WIDTH:0]     in_dy,
    input  wire  signed [COORD_WIDTH-1:0]   in_qx,
    input  wire  signed [COORD_WIDTH-1:0]   in_qy,
    output logic                            out_valid,
    output scp_pkg::region_t                out_region,
    output logic                            out_degen,
    output logic signed [COORD_WIDTH-1:0]   out_cx,
    output logic signed [COORD_WIDTH-1:0]   out_cy,
    output logic signed [COORD_WIDTH-1:0]   out_qx,
    output logic signed [COORD_WIDTH-1:0]   out_qy
);
    import scp_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int MW = T_FRAC_BITS + DW;

    logic [DW-1:0] ax, ay;
    assign ax = in_dx[DW-1] ? DW'(-in_dx) : DW'(in_dx);
    assign ay = in_dy[DW-1] ? DW'(-in_dy) : DW'(in_dy);

    // stage 1: t times |d|
    logic            v1_reg;
    region_t         region1_reg;
    logic            degen1_reg, nx1_reg, ny1_reg;
    logic [W-1:0]    sx1_reg, sy1_reg, ex1_reg, ey1_reg, qx1_reg, qy1_reg;
    logic [MW-1:0]   mx1_reg, my1_reg;
    // stage 2: round, apply sign, select by region
    logic            v2_reg;

    logic [MW-1:0]   rx, ry;
    logic [W-1:0]    cx_next, cy_next;
    logic [W-1:0]    ix, iy;

    // round half away from zero on the magnitude
    assign rx = mx1_reg + (MW'(1) << (T_FRAC_BITS - 1));
    assign ry = my1_reg + (MW'(1) << (T_FRAC_BITS - 1));
    assign ix = nx1_reg ? sx1_reg - rx[T_FRAC_BITS +: W] : sx1_reg + rx[T_FRAC_BITS +: W];
    assign iy = ny1_reg ? sy1_reg - ry[T_FRAC_BITS +: W] : sy1_reg + ry[T_FRAC_BITS +: W];

    always_comb
    begin
        unique case (region1_reg)
            REGION_INTERIOR:
            begin
                cx_next = ix;
                cy_next = iy;
            end
            REGION_END:
            begin
                cx_next = ex1_reg;
                cy_next = ey1_reg;
            end
            default:
            begin
                cx_next = sx1_reg;
                cy_next = sy1_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        region1_reg <= in_region;
        degen1_reg  <= in_degen;
        nx1_reg     <= in_dx[DW-1];
        ny1_reg     <= in_dy[DW-1];
        sx1_reg     <= in_sx;
        sy1_reg     <= in_sy;
        ex1_reg     <= in_sx + in_dx[W-1:0];
        ey1_reg     <= in_sy + in_dy[W-1:0];
        qx1_reg     <= in_qx;
        qy1_reg     <= in_qy;
        mx1_reg     <= MW'(in_t) * MW'(ax);
        my1_reg     <= MW'(in_t) * MW'(ay);

        out_region  <= region1_reg;
        out_degen   <= degen1_reg;
        out_cx      <= cx_next;
        out_cy      <= cy_next;
        out_qx      <= qx1_reg;
        out_qy      <= qy1_reg;
    end

    assign out_valid = v2_reg;

endmodule

`default_nettype wire

// ----- design/scp_dist.sv -----
`timescale 1ns / 1ps
`default_nettype none

module scp_dist #(
    parameter int COORD_WIDTH = 32
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             in_valid,
    input  scp_pkg::region_t                in_region,
    input  wire                             in_degen,
    input  wire  signed [COORD_WIDTH-1:0]   in_cx,
    input  wire  signed [COORD_WIDTH-1:0]   in_cy,
    input  wire  signed [COORD_WIDTH-1:0]   in_qx,
    input  wire  signed [COORD_WIDTH-1:0]   in_qy,
    output logic                            out_valid,
    output scp_pkg::region_t                out_region,
    output logic                            out_degen,
    output logic signed [COORD_WIDTH-1:0]   out_cx,
    output logic signed [COORD_WIDTH-1:0]   out_cy,
    output logic [COORD_WIDTH:0]            out_dist
);
    import scp_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int PW = 2 * DW;
    localparam int K  = W + 2;       // root bits
    localparam int NW = 2 * K;       // radicand bits
    localparam int RW = K + 2;       // remainder bits
    localparam int SB = 2 + 1 + 2 * W;

    typedef logic [SB-1:0] side_t;

    // stage 1: difference magnitudes
    logic             v1_reg;
    side_t            side1_reg;
    logic [DW-1:0]    ex1_reg, ey1_reg;
    // stage 2: squares
    logic             v2_reg;
    side_t            side2_reg;
    logic [PW-1:0]    sqx2_reg, sqy2_reg;
    // stage 3: sum of squares
    logic             v3_reg;
    side_t            side3_reg;
    logic [NW-1:0]    n3_reg;

    logic signed [DW-1:0] ddx, ddy;
    assign ddx = DW'(in_qx) - DW'(in_cx);
    assign ddy = DW'(in_qy) - DW'(in_cy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        side1_reg <= {in_region, in_degen, in_cx, in_cy};
        ex1_reg   <= ddx[DW-1] ? DW'(-ddx) : DW'(ddx);
        ey1_reg   <= ddy[DW-1] ? DW'(-ddy) : DW'(ddy);
        side2_reg <= side1_reg;
        sqx2_reg  <= PW'(ex1_reg) * PW'(ex1_reg);
        sqy2_reg  <= PW'(ey1_reg) * PW'(ey1_reg);
        side3_reg <= side2_reg;
        n3_reg    <= NW'(sqx2_reg) + NW'(sqy2_reg);
    end

    // digit-by-digit square root, one root bit per stage
    logic          sv_reg    [K];
    side_t         sside_reg [K];
    logic [NW-1:0] sn_reg    [K];
    logic [RW-1:0] srem_reg  [K];
    logic [K-1:0]  sroot_reg [K];

    for (genvar i = 0; i < K; i++)
    begin : g_sqrt
        logic          v_in;
        side_t         side_in;
        logic [NW-1:0] n_in;
        logic [RW-1:0] rem_in;
        logic [K-1:0]  root_in;
        logic [RW+1:0] cand, trial, diff;
        logic          ge;

        if (i == 0)
        begin : g_first
            assign v_in    = v3_reg;
            assign side_in = side3_reg;
            assign n_in    = n3_reg;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign v_in    = sv_reg[i-1];
            assign side_in = sside_reg[i-1];
            assign n_in    = sn_reg[i-1];
            assign rem_in  = srem_reg[i-1];
            assign root_in = sroot_reg[i-1];
        end

        assign cand  = {rem_in, n_in[NW-1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign ge    = (cand >= trial);
        assign diff  = cand - trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[i] <= 1'b0;
            end
            else
            begin
                sv_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            sside_reg[i] <= side_in;
            sn_reg[i]    <= {n_in[NW-3:0], 2'b00};
            srem_reg[i]  <= ge ? diff[RW-1:0] : cand[RW-1:0];
            sroot_reg[i] <= {root_in[K-2:0], ge};
        end
    end

    // round to nearest: remainder n - r*r above r means the root is nearer r + 1
    logic [K:0]    rounded;
    logic          v_out_reg;
    logic [DW-1:0] dist_next;

    assign rounded   = {1'b0, sroot_reg[K-1]}
                       + (K+1)'(srem_reg[K-1] > RW'(sroot_reg[K-1]));
    assign dist_next = (rounded > (K+1)'({DW{1'b1}})) ? {DW{1'b1}} : rounded[DW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_out_reg <= 1'b0;
        end
        else
        begin
            v_out_reg <= sv_reg[K-1];
        end
    end

    always_ff @(posedge clk)
    begin
        out_region <= region_t'(sside_reg[K-1][SB-1 -: 2]);
        {out_degen, out_cx, out_cy} <= sside_reg[K-1][SB-3:0];
        out_dist <= dist_next;
    end

    assign out_valid = v_out_reg;

endmodule

`default_nettype wire

// ----- design/scp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module scp_checker #(
    parameter int COORD_WIDTH = 32,
    parameter int T_FRAC_BITS = 24
) (
    input wire       clk,
    input wire       rst_n,
    input wire       start,
    input wire       busy,
    input wire       done,
    input wire [1:0] region,
    input wire       degenerate
);
    import scp_pkg::*;

    localparam int LAT = scp_latency(COORD_WIDTH, T_FRAC_BITS);

    // a result only ever follows a transfer taken a fixed latency earlier
    `SCP_ASSERT(a_done_after_start, clk, rst_n, done |-> $past(start && !busy, LAT))

    // the block never refuses a transfer
    `SCP_ASSERT_ALWAYS(a_never_busy, clk, !busy)

    // degenerate segments report the start region
    `SCP_ASSERT(a_degen_region, clk, rst_n, (done && degenerate) |-> (region == REGION_START))

    // region code 3 never shows
    `SCP_ASSERT(a_region_code, clk, rst_n, done |-> (region != 2'd3))

endmodule

bind segment_closest_point_core scp_checker #(
    .COORD_WIDTH (COORD_WIDTH),
    .T_FRAC_BITS (T_FRAC_BITS)
) u_scp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .region     (region),
    .degenerate (degenerate)
);

`default_nettype wire
